// ===== hw/rtl/omb_pkg.sv =====
// ----------------------------------------------------------------------------
// Omni base package
// Shared widths, register indexes, pipeline control type and the wheel
// rounding and saturation function.
// ----------------------------------------------------------------------------
package omb_pkg;

    // Field widths.
    localparam int CMD_W   = 16;
    localparam int STEP_W  = 15;
    localparam int GAIN_W  = 16;
    localparam int WHEEL_W = 18;
    localparam int PROD_W  = CMD_W + GAIN_W + 1;
    localparam int SUM_W   = PROD_W + 2;
    localparam int CFG_AW  = 3;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] REG_STEP_X = 3'd0;
    localparam logic [CFG_AW-1:0] REG_STEP_Y = 3'd1;
    localparam logic [CFG_AW-1:0] REG_GAIN_X = 3'd2;
    localparam logic [CFG_AW-1:0] REG_GAIN_Y = 3'd3;
    localparam logic [CFG_AW-1:0] REG_GAIN_W = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [STEP_W-1:0] STEP_X_RST = 15'd41;
    localparam logic [STEP_W-1:0] STEP_Y_RST = 15'd41;
    localparam logic [GAIN_W-1:0] GAIN_X_RST = 16'd14189;
    localparam logic [GAIN_W-1:0] GAIN_Y_RST = 16'd8192;
    localparam logic [GAIN_W-1:0] GAIN_W_RST = 16'd8192;

    // Stage advance strobes for the product and result stages.
    typedef struct packed {
        logic adv_prod;
        logic adv_out;
    } pipe_ctl_t;

    // Round a Q.26 wheel sum to Q.12 (half up, floor shift), then clamp.
    function automatic logic signed [WHEEL_W-1:0] wheel_finish(
        input logic signed [SUM_W-1:0] sum
    );
        logic signed [SUM_W:0]  biased;
        logic signed [SUM_W-14:0] shifted;
        logic signed [WHEEL_W-1:0] res;
        biased  = {sum[SUM_W-1], sum} + (SUM_W+1)'(8192);
        shifted = biased[SUM_W:14];
        if (shifted > (SUM_W-13)'(131071)) begin
            res = 18'sh1FFFF;
        end else if (shifted < -(SUM_W-13)'(131072)) begin
            res = 18'sh20000;
        end else begin
            res = shifted[WHEEL_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/omb_slew.sv =====
// ----------------------------------------------------------------------------
// Omni base slew stage
// Limits the X and Y commands against the values last used and registers
// the limited values, which also serve as the slew state.
// ----------------------------------------------------------------------------
module omb_slew
    import omb_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  logic signed [CMD_W-1:0]  cmd_vx,
    input  logic signed [CMD_W-1:0]  cmd_vy,
    input  logic signed [CMD_W-1:0]  cmd_w,
    input  logic        [STEP_W-1:0] step_x,
    input  logic        [STEP_W-1:0] step_y,
    output logic signed [CMD_W-1:0]  vx_reg,
    output logic signed [CMD_W-1:0]  vy_reg,
    output logic signed [CMD_W-1:0]  w_reg
);

    logic signed [CMD_W-1:0] vx_next;
    logic signed [CMD_W-1:0] vy_next;

    // One step toward the command, never past it.
    function automatic logic signed [CMD_W-1:0] slew(
        input logic signed [CMD_W-1:0]  prev,
        input logic signed [CMD_W-1:0]  cmd,
        input logic        [STEP_W-1:0] step
    );
        logic signed [CMD_W+1:0] diff;
        logic signed [CMD_W+1:0] stp;
        logic signed [CMD_W+1:0] res;
        diff = (CMD_W+2)'(cmd) - (CMD_W+2)'(prev);
        stp  = $signed({3'b000, step});
        if (diff > stp) begin
            res = (CMD_W+2)'(prev) + stp;
        end else if (diff < -stp) begin
            res = (CMD_W+2)'(prev) - stp;
        end else begin
            res = (CMD_W+2)'(cmd);
        end
        return res[CMD_W-1:0];
    endfunction

    assign vx_next = slew(vx_reg, cmd_vx, step_x);
    assign vy_next = slew(vy_reg, cmd_vy, step_y);

    // Limited values hold the slew state and are cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vx_reg <= '0;
            vy_reg <= '0;
        end else if (load) begin
            vx_reg <= vx_next;
            vy_reg <= vy_next;
        end
    end

    // The rotation command passes through unlimited.
    always_ff @(posedge aclk) begin
        if (load) begin
            w_reg <= cmd_w;
        end
    end

endmodule

// ===== hw/rtl/omb_mix.sv =====
// ----------------------------------------------------------------------------
// Omni base wheel mixer
// Scales the three axes by their gains, then mixes, rounds and saturates
// the four wheel targets into the result register.
// ----------------------------------------------------------------------------
module omb_mix
    import omb_pkg::*;
(
    input  logic                      aclk,
    input  pipe_ctl_t                 ctl,
    input  logic signed [CMD_W-1:0]   vx,
    input  logic signed [CMD_W-1:0]   vy,
    input  logic signed [CMD_W-1:0]   w,
    input  logic        [GAIN_W-1:0]  gain_x,
    input  logic        [GAIN_W-1:0]  gain_y,
    input  logic        [GAIN_W-1:0]  gain_w,
    output logic signed [WHEEL_W-1:0] fl_reg,
    output logic signed [WHEEL_W-1:0] fr_reg,
    output logic signed [WHEEL_W-1:0] br_reg,
    output logic signed [WHEEL_W-1:0] bl_reg
);

    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [PROD_W-1:0] pw_reg;
    logic signed [SUM_W-1:0]  sx;
    logic signed [SUM_W-1:0]  sy;
    logic signed [SUM_W-1:0]  sw;

    // Product stage: signed command times unsigned gain, Q.26.
    always_ff @(posedge aclk) begin
        if (ctl.adv_prod) begin
            px_reg <= PROD_W'(vx) * PROD_W'($signed({1'b0, gain_x}));
            py_reg <= PROD_W'(vy) * PROD_W'($signed({1'b0, gain_y}));
            pw_reg <= PROD_W'(w) * PROD_W'($signed({1'b0, gain_w}));
        end
    end

    assign sx = SUM_W'(px_reg);
    assign sy = SUM_W'(py_reg);
    assign sw = SUM_W'(pw_reg);

    // Result stage: exact wheel sums, rounded once and clamped.
    always_ff @(posedge aclk) begin
        if (ctl.adv_out) begin
            fl_reg <= wheel_finish(-sy - sx - sw);
            fr_reg <= wheel_finish(sy - sx - sw);
            br_reg <= wheel_finish(sy + sx - sw);
            bl_reg <= wheel_finish(-sy + sx - sw);
        end
    end

endmodule

// ===== hw/rtl/omni_base_slew_and_wheel_mix_top.sv =====
// ----------------------------------------------------------------------------
// Omni base slew limiter and wheel mixer, top level
// Slew-limits X and Y body velocity commands and mixes them with rotation
// into four omni-wheel target speeds.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one body-velocity command per transfer; the
//   master stream returns one transfer with four wheel targets for each.
//   The configuration port writes step limits and gains at any edge where
//   cfg_wen is high; write it only while the block is idle.
//   A command accepted at an edge passes the slew, product, then mix and
//   saturate registers in that order; m_tvalid rises when it reaches the
//   last of them. Throughput is one command per cycle while the receiver
//   does not stall; the slew compare and step on the input register is the
//   only feedback path.
//   Each stage holds its own valid bit, so a command is still accepted while
//   a result waits, as long as an empty stage remains. When the receiver
//   stalls with all three stages full, s_tready drops until the result is
//   taken.
//   Reset clears the slew state to zero, empties the pipeline and loads the
//   default step limits and gains.
// ----------------------------------------------------------------------------
module omni_base_slew_and_wheel_mix_top
    import omb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write port.
    input  logic              cfg_wen,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [GAIN_W-1:0] cfg_wdata,
    // Command stream.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,   // cmd_vx, cmd_vy, cmd_w
    // Wheel target stream.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata    // front_left, front_right, back_right, back_left
);

    logic [STEP_W-1:0] step_x_reg;
    logic [STEP_W-1:0] step_y_reg;
    logic [GAIN_W-1:0] gain_x_reg;
    logic [GAIN_W-1:0] gain_y_reg;
    logic [GAIN_W-1:0] gain_w_reg;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic en1;
    logic en2;
    logic en3;
    logic accept;
    pipe_ctl_t ctl;

    logic signed [CMD_W-1:0]   vx;
    logic signed [CMD_W-1:0]   vy;
    logic signed [CMD_W-1:0]   w;
    logic signed [WHEEL_W-1:0] fl;
    logic signed [WHEEL_W-1:0] fr;
    logic signed [WHEEL_W-1:0] br;
    logic signed [WHEEL_W-1:0] bl;

    // Configuration registers; writes to unused indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_x_reg <= STEP_X_RST;
            step_y_reg <= STEP_Y_RST;
            gain_x_reg <= GAIN_X_RST;
            gain_y_reg <= GAIN_Y_RST;
            gain_w_reg <= GAIN_W_RST;
        end else if (cfg_wen) begin
            unique case (cfg_addr)
                REG_STEP_X: step_x_reg <= cfg_wdata[STEP_W-1:0];
                REG_STEP_Y: step_y_reg <= cfg_wdata[STEP_W-1:0];
                REG_GAIN_X: gain_x_reg <= cfg_wdata;
                REG_GAIN_Y: gain_y_reg <= cfg_wdata;
                REG_GAIN_W: gain_w_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or the stage after it moves on.
    assign en3    = !v3_reg || m_tready;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign accept = s_tvalid && en1;
    assign s_tready = en1;

    assign ctl.adv_prod = en2 && v1_reg;
    assign ctl.adv_out  = en3 && v2_reg;

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    omb_slew u_slew (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .cmd_vx  ($signed(s_tdata[15:0])),
        .cmd_vy  ($signed(s_tdata[31:16])),
        .cmd_w   ($signed(s_tdata[47:32])),
        .step_x  (step_x_reg),
        .step_y  (step_y_reg),
        .vx_reg  (vx),
        .vy_reg  (vy),
        .w_reg   (w)
    );

    omb_mix u_mix (
        .aclk   (aclk),
        .ctl    (ctl),
        .vx     (vx),
        .vy     (vy),
        .w      (w),
        .gain_x (gain_x_reg),
        .gain_y (gain_y_reg),
        .gain_w (gain_w_reg),
        .fl_reg (fl),
        .fr_reg (fr),
        .br_reg (br),
        .bl_reg (bl)
    );

    assign m_tvalid = v3_reg;
    assign m_tdata  = {bl, br, fr, fl};

endmodule
